// ===== rtl/drawing_tablet_serial_port_unit_assert.svh =====
// Assertion macros shared by the RTL of the tablet port unit.
`ifndef DRAWING_TABLET_SERIAL_PORT_UNIT_ASSERT_SVH
`define DRAWING_TABLET_SERIAL_PORT_UNIT_ASSERT_SVH

// Same-cycle implication, gated by reset.
`define DTSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, gated by reset.
`define DTSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/dtsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dtsp_pkg;

    localparam int WORD_W = 18;
    localparam int PTR_W  = 5;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    localparam logic [3:0] READ_IDLE = 4'd0;
    localparam logic [3:0] READ_WAIT = 4'd4;
    localparam logic [3:0] READ_LOW  = 4'd8;
    localparam logic [3:0] READ_HIGH = 4'd0;

    localparam logic [PTR_W-1:0] PTR_MAX  = 5'd19;
    localparam logic [PTR_W-1:0] PTR_LAST = 5'd18;

    typedef struct packed {
        mode_t              mode;
        logic signed [9:0]  pen_x;
        logic signed [9:0]  pen_y;
        logic               pen_button;
        logic [7:0]         write_value;
    } item_t;

    typedef struct packed {
        logic               fire;
        mode_t              mode;
        logic [1:0]         strobe;
        logic [WORD_W-1:0]  word;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/dtsp_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dtsp_in_if;

    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic signed [9:0] pen_x;
    logic signed [9:0] pen_y;
    logic              pen_button;
    logic [7:0]        write_value;

    modport source (
        output valid, mode, pen_x, pen_y, pen_button, write_value,
        input  ready
    );

    modport sink (
        input  valid, mode, pen_x, pen_y, pen_button, write_value,
        output ready
    );

endinterface

`default_nettype wire

// ===== rtl/dtsp_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dtsp_out_if;

    logic       valid;
    logic       ready;
    logic [3:0] read_data;

    modport source (
        output valid, read_data,
        input  ready
    );

    modport sink (
        input  valid, read_data,
        output ready
    );

endinterface

`default_nettype wire

// ===== rtl/drawing_tablet_serial_port_unit.sv =====
// Channel     Dir   Payload                                            Handshake
// sample_in   in    mode, pen_x, pen_y, pen_button, write_value        valid/ready
// result_out  out   read_data (only for port reads)                     valid/ready
//
// One request is accepted per cycle while the stage register can pass its request on.
// The stage register hands one request per cycle to the port logic and the result register,
// but a read waits in it while the result register holds an untaken value.
// Samples and writes never wait on the output side.
// rst_n clears the tablet state (pending word, shift word, strobe, pointer) to zero.
`timescale 1ns / 1ps
`default_nettype none

`include "drawing_tablet_serial_port_unit_assert.svh"

module drawing_tablet_serial_port_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dtsp_in_if.sink    sample_in,
    dtsp_out_if.source result_out
);
    import dtsp_pkg::*;

    item_t             stage_reg;
    logic              stage_valid_reg;
    logic              stage_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [3:0]        read_data_reg;
    logic              is_read;
    logic              out_free;
    logic              fire;
    logic              accept;
    logic [WORD_W-1:0] word;
    logic [3:0]        port_data;
    cmd_t              cmd;

    always_comb
    begin
        is_read          = (stage_reg.mode == MODE_READ);
        out_free         = !out_valid_reg || result_out.ready;
        fire             = stage_valid_reg && (!is_read || out_free);
        sample_in.ready  = !stage_valid_reg || fire;
        accept           = sample_in.valid && sample_in.ready;
        stage_valid_next = accept ? 1'b1 : (fire ? 1'b0 : stage_valid_reg);
        out_valid_next   = (fire && is_read) ? 1'b1 :
                           (result_out.ready ? 1'b0 : out_valid_reg);
        cmd.fire         = fire;
        cmd.mode         = stage_reg.mode;
        cmd.strobe       = stage_reg.write_value[1:0];
        cmd.word         = word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.mode        <= mode_t'(sample_in.mode);
            stage_reg.pen_x       <= sample_in.pen_x;
            stage_reg.pen_y       <= sample_in.pen_y;
            stage_reg.pen_button  <= sample_in.pen_button;
            stage_reg.write_value <= sample_in.write_value;
        end
        if (fire && is_read)
        begin
            read_data_reg <= port_data;
        end
    end

    dtsp_word u_word (
        .pen_x      (stage_reg.pen_x),
        .pen_y      (stage_reg.pen_y),
        .pen_button (stage_reg.pen_button),
        .word       (word)
    );

    dtsp_port u_port (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .read_data (port_data)
    );

    assign result_out.valid     = out_valid_reg;
    assign result_out.read_data = read_data_reg;

    `DTSP_ASSERT_NEXT(a_read_shows, clk, rst_n, fire && is_read, out_valid_reg)
    `DTSP_ASSERT_NEXT(a_read_waits, clk, rst_n,
        stage_valid_reg && is_read && out_valid_reg && !result_out.ready,
        stage_valid_reg && $stable(stage_reg))
    `DTSP_ASSERT_NEXT(a_result_drains, clk, rst_n,
        out_valid_reg && result_out.ready && !(fire && is_read),
        !out_valid_reg)

endmodule

`default_nettype wire

// ===== rtl/dtsp_word.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtsp_word (
    input  wire logic signed [9:0]            pen_x,
    input  wire logic signed [9:0]            pen_y,
    input  wire logic                         pen_button,
    output logic [dtsp_pkg::WORD_W-1:0]       word
);
    import dtsp_pkg::*;

    localparam logic signed [9:0] X_MAX    = 10'sd255;
    localparam logic signed [9:0] Y_MAX    = 10'sd239;
    localparam logic [8:0]        X_OFFSET = 9'd8;
    localparam logic [7:0]        X_SCALE  = 8'd240;
    localparam logic [7:0]        Y_OFFSET = 8'd14;
    localparam logic [7:0]        Y_RECIP  = 8'd137;
    localparam logic [7:0]        Y_HIGH   = 8'd48;

    logic        off_area;
    logic [7:0]  x_pos;
    logic [7:0]  y_pos;
    logic [16:0] x_prod;
    logic [7:0]  x_scaled;
    logic [7:0]  y_diff;
    logic [15:0] y_prod;
    logic [7:0]  y_scaled;

    always_comb
    begin
        off_area = (pen_x < 10'sd0) || (pen_x > X_MAX) ||
                   (pen_y < 10'sd0) || (pen_y > Y_MAX);
        x_pos    = off_area ? 8'd0 : pen_x[7:0];
        y_pos    = off_area ? 8'd0 : pen_y[7:0];

        x_prod   = ({1'b0, x_pos} + X_OFFSET) * X_SCALE;
        x_scaled = x_prod[15:8];

        // y * 16 / 15 == y + y / 15
        y_diff   = y_pos - Y_OFFSET;
        y_prod   = y_diff * Y_RECIP;
        y_scaled = (y_pos < Y_OFFSET) ? 8'd0 : (y_diff + {4'd0, y_prod[14:11]});

        word = {x_scaled, y_scaled, (y_pos >= Y_HIGH) | pen_button, pen_button};
    end

endmodule

`default_nettype wire

// ===== rtl/dtsp_port.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "drawing_tablet_serial_port_unit_assert.svh"

module dtsp_port (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire dtsp_pkg::cmd_t cmd,
    output logic [3:0]        read_data
);
    import dtsp_pkg::*;

    logic [WORD_W-1:0] pending_reg;
    logic [WORD_W-1:0] pending_next;
    logic [WORD_W-1:0] shift_reg;
    logic [WORD_W-1:0] shift_next;
    logic [1:0]        strobe_reg;
    logic [1:0]        strobe_next;
    logic [PTR_W-1:0]  index_reg;
    logic [PTR_W-1:0]  index_next;
    logic [PTR_W-1:0]  bit_sel;
    logic              cur_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            shift_reg   <= '0;
            strobe_reg  <= '0;
            index_reg   <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            shift_reg   <= shift_next;
            strobe_reg  <= strobe_next;
            index_reg   <= index_next;
        end
    end

    always_comb
    begin
        pending_next = pending_reg;
        shift_next   = shift_reg;
        strobe_next  = strobe_reg;
        index_next   = index_reg;
        if (cmd.fire)
        begin
            unique case (cmd.mode)
                MODE_SAMPLE:
                begin
                    pending_next = cmd.word;
                end
                MODE_WRITE:
                begin
                    strobe_next = cmd.strobe;
                    if (cmd.strobe[0])
                    begin
                        if (!strobe_reg[1] && cmd.strobe[1] && (index_reg < PTR_MAX))
                        begin
                            index_next = index_reg + 5'd1;
                        end
                    end
                    else
                    begin
                        shift_next = pending_reg;
                        index_next = '0;
                    end
                end
                MODE_READ, MODE_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        bit_sel = PTR_LAST - index_reg;
        cur_bit = 1'b0;
        if ((index_reg != '0) && (index_reg <= PTR_LAST))
        begin
            cur_bit = shift_reg[bit_sel];
        end
        priority if (!strobe_reg[0])
        begin
            read_data = READ_IDLE;
        end
        else if (!strobe_reg[1])
        begin
            read_data = READ_WAIT;
        end
        else
        begin
            read_data = cur_bit ? READ_HIGH : READ_LOW;
        end
    end

    `DTSP_ASSERT_NOW(a_index_bound, clk, rst_n, 1'b1, index_reg <= PTR_MAX)
    `DTSP_ASSERT_NEXT(a_latch_rewind, clk, rst_n,
        cmd.fire && (cmd.mode == MODE_WRITE) && !cmd.strobe[0],
        (index_reg == '0) && (shift_reg == $past(pending_reg)))
    `DTSP_ASSERT_NEXT(a_port_hold, clk, rst_n,
        !(cmd.fire && (cmd.mode == MODE_WRITE)),
        $stable(index_reg) && $stable(strobe_reg) && $stable(shift_reg))

endmodule

`default_nettype wire
